// ----- sv/crc_frame_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// crc frame deframer assertion macros
// shared assertion wrappers, clocked on clock, reset is synchronous active high
// ----------------------------------------------------------------------------
`ifndef CRC_FRAME_DEFRAMER_DEFINES_SVH
`define CRC_FRAME_DEFRAMER_DEFINES_SVH

// property checked outside reset
`define CFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property checked at every edge, reset included
`define CFD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// types, constants and the crc step shared by the frame deframer
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;

   // header bytes after the sync pair: version, type, sequence, reserved, len lo, len hi
   localparam int          HDR_FIELDS  = 6;
   localparam logic [2:0]  HDR_LEN_LO  = 3'd4;
   localparam logic [2:0]  HDR_LAST    = 3'd5;

   localparam int          CSR_INDEX_W = 8;
   localparam int          CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPECTED_VERSION = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PAYLOAD_LIMIT    = 8'd1;

   localparam logic [7:0]  EXPECTED_VERSION_RST = 8'd1;
   localparam logic [8:0]  PAYLOAD_LIMIT_RST    = 9'd256;

   typedef enum logic [1:0] {
      STATUS_BUSY    = 2'd0,
      STATUS_PAYLOAD = 2'd1,
      STATUS_GOOD    = 2'd2,
      STATUS_ERROR   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] expected_version;
      logic [8:0] payload_limit;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] frame_type;
      logic [7:0] frame_sequence;
      logic [8:0] payload_length;
   } rsp_type;

   // crc-16/ccitt-false, one byte msb first
   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ----- sv/cfd_channels.sv -----
// ----------------------------------------------------------------------------
// cfd channels
// valid/ready channel interfaces for bytes in, results out and register writes
// ----------------------------------------------------------------------------
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic [7:0] frame_type;
   logic [7:0] frame_sequence;
   logic [8:0] payload_length;

   modport source (output valid, output status, output payload_byte,
                   output payload_index, output frame_type, output frame_sequence,
                   output payload_length, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input payload_index, input frame_type, input frame_sequence,
                   input payload_length, output ready);
endinterface

interface cfd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cfd_pkg::CSR_INDEX_W-1:0] index;
   logic [cfd_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- sv/crc_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// crc_frame_deframer
// byte-serial deframer: sync hunt, header check, crc-16 check, payload stream
// ----------------------------------------------------------------------------
//  channel   dir  transfer carries
//  req_ch    in   data_byte, one received link byte
//  rsp_ch    out  status, payload_byte/index, frame_type/sequence, payload_length
//  csr_ch    in   index, wdata (0 expected_version, 1 payload_limit)
//
//  one byte per cycle sustained while results are taken; every byte gives exactly one result
//  a byte passes the input register, then the sequencer into the result register
//  the per-byte crc step is an eight-step xor network between those registers
//  reset clears the sequencer to the sync hunt and restores register defaults
//  a stalled result holds; the input register still takes one more byte behind it
// ----------------------------------------------------------------------------
module crc_frame_deframer #(
   parameter int MAX_PAYLOAD = 256
) (
   input logic              clock,
   input logic              reset,
   cfd_req_if.sink          req_ch,
   cfd_rsp_if.source        rsp_ch,
   cfd_csr_if.sink          csr_ch
);

   // configuration registers
   logic [7:0]       expected_version_ff;
   logic [8:0]       payload_limit_ff;
   cfd_pkg::cfg_type cfg;

   // input register to sequencer
   logic             byte_valid;
   logic             byte_ready;
   logic [7:0]       byte_data;

   cfd_pkg::rsp_type rsp;

   // register port never stalls; unknown indexes are dropped
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= cfd_pkg::EXPECTED_VERSION_RST;
         payload_limit_ff    <= cfd_pkg::PAYLOAD_LIMIT_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            cfd_pkg::REG_EXPECTED_VERSION: expected_version_ff <= csr_ch.wdata[7:0];
            cfd_pkg::REG_PAYLOAD_LIMIT:    payload_limit_ff    <= csr_ch.wdata[8:0];
            default: ;
         endcase
      end
   end

   assign cfg.expected_version = expected_version_ff;
   assign cfg.payload_limit    = payload_limit_ff;

   // input register: takes a byte while the sequencer works on the previous one
   cfd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_ch.data_byte),
      .out_valid (byte_valid),
      .out_ready (byte_ready),
      .out_data  (byte_data)
   );

   // frame sequencer with its result register
   cfd_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (byte_valid),
      .in_ready  (byte_ready),
      .in_data   (byte_data),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp       (rsp)
   );

   // result fields onto the channel
   assign rsp_ch.status         = rsp.status;
   assign rsp_ch.payload_byte   = rsp.payload_byte;
   assign rsp_ch.payload_index  = rsp.payload_index;
   assign rsp_ch.frame_type     = rsp.frame_type;
   assign rsp_ch.frame_sequence = rsp.frame_sequence;
   assign rsp_ch.payload_length = rsp.payload_length;

endmodule

// ----- sv/cfd_in_reg.sv -----
// ----------------------------------------------------------------------------
// cfd_in_reg
// input register for received bytes, refills in the cycle it drains
// ----------------------------------------------------------------------------
module cfd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ----- sv/cfd_core.sv -----
// ----------------------------------------------------------------------------
// cfd_core
// frame sequencer: sync hunt, header check, crc, payload tagging, result register
// ----------------------------------------------------------------------------
module cfd_core #(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  cfd_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfd_pkg::rsp_type rsp
);

   // the 9-bit limit register caps any accepted length at 511
   localparam int LIMIT_MAX = (MAX_PAYLOAD < 511) ? MAX_PAYLOAD : 511;
   localparam int LEN_W     = $clog2(LIMIT_MAX + 1);
   localparam logic [15:0] MAX_LIMIT = 16'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [2:0]        hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]        version_ff, version_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        seq_ff, seq_in;
   logic [7:0]        len_lo_ff, len_lo_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cfd_pkg::rsp_type  rsp_ff, rsp_in;

   logic              advance;
   logic [15:0]       crc_step;
   logic [15:0]       len16;
   logic [15:0]       lim16;
   logic [15:0]       cfg_limit16;
   logic [LEN_W:0]    cnt_next;
   logic [LEN_W+7:0]  index_wide;
   logic [LEN_W+8:0]  length_wide;

   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign crc_step    = cfd_pkg::crc_add_byte(crc_ff, in_data);
   assign len16       = {in_data, len_lo_ff};
   assign cfg_limit16 = {7'd0, cfg.payload_limit};
   assign lim16       = (cfg_limit16 > MAX_LIMIT) ? MAX_LIMIT : cfg_limit16;
   assign cnt_next    = {1'b0, cnt_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign index_wide  = {8'd0, cnt_ff};
   assign length_wide = {9'd0, len_ff};

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      version_in = version_ff;
      type_in    = type_ff;
      seq_in     = seq_ff;
      len_lo_in  = len_lo_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;

      rsp_in                = '0;
      rsp_in.status         = cfd_pkg::STATUS_BUSY;

      case (phase_ff)
         PH_SYNC1: begin
            if (in_data == cfd_pkg::SYNC_FIRST) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (in_data == cfd_pkg::SYNC_SECOND) begin
               phase_in   = PH_HEADER;
               hdr_cnt_in = 3'd0;
               crc_in     = cfd_pkg::CRC_INIT;
            end else if (in_data != cfd_pkg::SYNC_FIRST) begin
               phase_in = PH_SYNC1;
            end
         end
         PH_HEADER: begin
            crc_in     = crc_step;
            hdr_cnt_in = hdr_cnt_ff + 3'd1;
            case (hdr_cnt_ff)
               3'd0:                version_in = in_data;
               3'd1:                type_in    = in_data;
               3'd2:                seq_in     = in_data;
               cfd_pkg::HDR_LEN_LO: len_lo_in  = in_data;
               default: ;
            endcase
            if (hdr_cnt_ff == cfd_pkg::HDR_LAST) begin
               if (version_ff != cfg.expected_version || len16 > lim16) begin
                  phase_in      = PH_SYNC1;
                  rsp_in.status = cfd_pkg::STATUS_ERROR;
               end else begin
                  len_in   = len16[LEN_W-1:0];
                  cnt_in   = '0;
                  phase_in = (len16 == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            crc_in               = crc_step;
            cnt_in               = cnt_next[LEN_W-1:0];
            rsp_in.status        = cfd_pkg::STATUS_PAYLOAD;
            rsp_in.payload_byte  = in_data;
            rsp_in.payload_index = index_wide[7:0];
            if (cnt_next == {1'b0, len_ff}) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            crc_lo_in = in_data;
            phase_in  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            phase_in = PH_SYNC1;
            if ({in_data, crc_lo_ff} == crc_ff) begin
               rsp_in.status         = cfd_pkg::STATUS_GOOD;
               rsp_in.frame_type     = type_ff;
               rsp_in.frame_sequence = seq_ff;
               rsp_in.payload_length = length_wide[8:0];
            end else begin
               rsp_in.status = cfd_pkg::STATUS_ERROR;
            end
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         hdr_cnt_ff   <= 3'd0;
         cnt_ff       <= '0;
         crc_ff       <= cfd_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff   <= phase_in;
            hdr_cnt_ff <= hdr_cnt_in;
            cnt_ff     <= cnt_in;
            crc_ff     <= crc_in;
         end
      end
      if (advance) begin
         version_ff <= version_in;
         type_ff    <= type_in;
         seq_ff     <= seq_in;
         len_lo_ff  <= len_lo_in;
         len_ff     <= len_in;
         crc_lo_ff  <= crc_lo_in;
         rsp_ff     <= rsp_in;
      end
   end

endmodule

// ----- sv/cfd_checker.sv -----
// ----------------------------------------------------------------------------
// cfd_checker
// port-level checks on the deframer result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "crc_frame_deframer_defines.svh"

module cfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_payload_byte,
   input logic [7:0] rsp_payload_index,
   input logic [7:0] rsp_frame_type,
   input logic [7:0] rsp_frame_sequence,
   input logic [8:0] rsp_payload_length
);

   `CFD_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid,
      "result valid after reset")

   `CFD_ASSERT(a_rsp_holds, rsp_valid && !rsp_ready |=> rsp_valid,
      "stalled result dropped")

   `CFD_ASSERT(a_header_only_on_good,
      rsp_valid && rsp_status != cfd_pkg::STATUS_GOOD |->
         rsp_frame_type == 8'd0 && rsp_frame_sequence == 8'd0 &&
         rsp_payload_length == 9'd0,
      "header fields outside frame good")

   `CFD_ASSERT(a_payload_only_on_byte,
      rsp_valid && rsp_status != cfd_pkg::STATUS_PAYLOAD |->
         rsp_payload_byte == 8'd0 && rsp_payload_index == 8'd0,
      "payload fields outside payload transfer")

endmodule

bind crc_frame_deframer cfd_checker u_cfd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_payload_byte   (rsp_ch.payload_byte),
   .rsp_payload_index  (rsp_ch.payload_index),
   .rsp_frame_type     (rsp_ch.frame_type),
   .rsp_frame_sequence (rsp_ch.frame_sequence),
   .rsp_payload_length (rsp_ch.payload_length)
);
